/* hdl/lts_pkg.sv */
// ----------------------------------------------------------------------------
// LIFO tagged stack allocator package
// Shared types and fixed constants for the stack allocator block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lts_pkg;

    // Fixed field and register widths.
    localparam int FIELD_W  = 20;
    localparam int REGION_W = 21;
    localparam int TAG_W    = 8;
    localparam int TOTAL_W  = REGION_W + 1;

    // Frames are rounded to a multiple of sixteen bytes.
    localparam logic [REGION_W-1:0] ROUND_ADD  = REGION_W'(15);
    localparam logic [REGION_W-1:0] ROUND_MASK = ~REGION_W'(15);

    // Region size after reset.
    localparam logic [REGION_W-1:0] REGION_RESET = REGION_W'(1048576);

    // Request codes.
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

    // Input transaction.
    typedef struct packed {
        logic               req_type;
        logic [FIELD_W-1:0] byte_count;
        logic [TAG_W-1:0]   elem_type;
        logic [FIELD_W-1:0] elem_count;
        logic [FIELD_W-1:0] block_addr;
    } req_t;

    // Output transaction.
    typedef struct packed {
        logic               ok;
        logic [FIELD_W-1:0] alloc_addr;
    } resp_t;

    // One stored frame record.
    typedef struct packed {
        logic [REGION_W-1:0] size;
        logic [TAG_W-1:0]    tag;
        logic [FIELD_W-1:0]  length;
    } frame_t;

    // Stack update decided for one request.
    typedef struct packed {
        logic                push;
        logic                pop;
        logic [REGION_W-1:0] fp_next;
        frame_t              frame;
    } ctl_t;

endpackage : lts_pkg

`default_nettype wire

/* hdl/lifo_tagged_stack_allocator_top.sv */
// ----------------------------------------------------------------------------
// LIFO tagged stack allocator
// Last-in first-out frame allocator over a stack region starting at address 0.
// ----------------------------------------------------------------------------
// The block takes one request transaction per clock cycle while the output
// side is ready and returns exactly one result transaction for each, in order.
// A request is captured in an input register, then
// evaluated against the free pointer and the top frame, which is cached in
// registers; the next frame down is kept ready in the registered read port of
// the frame memory, so a push or pop in one cycle never stalls the next. The
// region size register may be written only while no transaction is in flight.
`timescale 1ns / 1ps
`default_nettype none

module lifo_tagged_stack_allocator_top #(
    parameter int HEADER_BYTES = 32,
    parameter int MAX_FRAMES   = 64,
    parameter int ADDR_BITS    = 20
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [lts_pkg::REGION_W-1:0]  cfg_wdata,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire lts_pkg::req_t                 in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output lts_pkg::resp_t                     out_data
);
    import lts_pkg::*;

    localparam int CW = $clog2(MAX_FRAMES + 1);
    localparam int IW = $clog2(MAX_FRAMES);

    logic [REGION_W-1:0] region_reg;
    logic [REGION_W-1:0] fp_reg;
    logic [CW-1:0]       count_reg;
    logic [CW-1:0]       count_next;
    frame_t              top_reg;
    frame_t              top_next;
    logic                s1_valid_reg;
    req_t                s1_data_reg;
    logic                out_valid_reg;
    resp_t               out_data_reg;

    logic                advance;
    resp_t               resp;
    ctl_t                ctl;
    frame_t              below;
    logic                mem_we;
    logic [CW-1:0]       wr_idx;
    logic [CW-1:0]       rd_idx;
    logic [IW-1:0]       mem_raddr;

    // Handshake: the input stage moves on when the result register frees up.
    assign advance   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Request evaluation.
    lts_decide #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_FRAMES   (MAX_FRAMES),
        .ADDR_BITS    (ADDR_BITS),
        .CW           (CW)
    ) u_decide (
        .req    (s1_data_reg),
        .region (region_reg),
        .fp     (fp_reg),
        .count  (count_reg),
        .top    (top_reg),
        .resp   (resp),
        .ctl    (ctl)
    );

    // Next frame count and top frame.
    always_comb
    begin
        count_next = count_reg;
        top_next   = top_reg;
        if (advance && ctl.push)
        begin
            count_next = count_reg + CW'(1);
            top_next   = ctl.frame;
        end
        else if (advance && ctl.pop)
        begin
            count_next = count_reg - CW'(1);
            top_next   = below;
        end
    end

    // The old top spills into memory on a push; the read port tracks the frame
    // just below the new top.
    assign mem_we    = advance && ctl.push && (count_reg != '0);
    assign wr_idx    = count_reg - CW'(1);
    assign rd_idx    = (count_next >= CW'(2)) ? (count_next - CW'(2)) : '0;
    assign mem_raddr = rd_idx[IW-1:0];

    lts_frame_ram #(
        .DEPTH (MAX_FRAMES),
        .IW    (IW)
    ) u_frame_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_idx[IW-1:0]),
        .wdata (top_reg),
        .raddr (mem_raddr),
        .rdata (below)
    );

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            region_reg    <= REGION_RESET;
            fp_reg        <= REGION_W'(HEADER_BYTES);
            count_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                region_reg <= cfg_wdata;
            end
            if (advance)
            begin
                fp_reg <= ctl.fp_next;
            end
            count_reg <= count_next;
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        top_reg <= top_next;
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (advance)
        begin
            out_data_reg <= resp;
        end
    end

endmodule : lifo_tagged_stack_allocator_top

`default_nettype wire

/* hdl/lts_frame_ram.sv */
// ----------------------------------------------------------------------------
// Frame record memory
// Holds the frames below the cached top frame. One write port and one read
// port with registered read data; a read of the address written in the same
// cycle returns the new data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lts_frame_ram #(
    parameter int DEPTH = 64,
    parameter int IW    = 6
) (
    input  wire logic            clk,
    input  wire logic            we,
    input  wire logic [IW-1:0]   waddr,
    input  wire lts_pkg::frame_t wdata,
    input  wire logic [IW-1:0]   raddr,
    output lts_pkg::frame_t      rdata
);
    import lts_pkg::*;

    frame_t frame_mem [DEPTH];
    frame_t rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            frame_mem[waddr] <= wdata;
        end
    end

    // Read port with write-through forwarding.
    always_ff @(posedge clk)
    begin
        if (we && (waddr == raddr))
        begin
            rdata_reg <= wdata;
        end
        else
        begin
            rdata_reg <= frame_mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule : lts_frame_ram

`default_nettype wire

/* hdl/lts_decide.sv */
// ----------------------------------------------------------------------------
// Request evaluation
// Works out the result and the stack update for one request from the free
// pointer, the frame count and the cached top frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lts_decide #(
    parameter int HEADER_BYTES = 32,
    parameter int MAX_FRAMES   = 64,
    parameter int ADDR_BITS    = 20,
    parameter int CW           = 7
) (
    input  wire lts_pkg::req_t                  req,
    input  wire logic [lts_pkg::REGION_W-1:0]   region,
    input  wire logic [lts_pkg::REGION_W-1:0]   fp,
    input  wire logic [CW-1:0]                  count,
    input  wire lts_pkg::frame_t                top,
    output lts_pkg::resp_t                      resp,
    output lts_pkg::ctl_t                       ctl
);
    import lts_pkg::*;

    localparam logic [FIELD_W-1:0] ADDR_MASK =
        FIELD_W'((64'd1 << ADDR_BITS) - 64'd1);
    localparam logic [TOTAL_W-1:0] HDR = TOTAL_W'(HEADER_BYTES);

    logic [REGION_W-1:0]  rounded;
    logic [TOTAL_W-1:0]   total;
    logic [TOTAL_W:0]     end_sum;
    logic [TOTAL_W-1:0]   base_hdr;
    logic                 fits;
    logic                 slot_free;
    logic [TOTAL_W-1:0]   below;
    logic [TOTAL_W-1:0]   exp_addr;
    logic                 match;

    // Frame size and allocation bounds.
    assign rounded   = ({1'b0, req.byte_count} + ROUND_ADD) & ROUND_MASK;
    assign total     = {1'b0, rounded} + HDR;
    assign end_sum   = {2'b00, fp} + {1'b0, total};
    assign fits      = end_sum <= {2'b00, region};
    assign slot_free = count < CW'(MAX_FRAMES);
    assign base_hdr  = {1'b0, fp} + HDR;

    // Top frame comparison for a release.
    assign below    = {1'b0, fp} - {1'b0, top.size};
    assign exp_addr = below + HDR;
    assign match    = (count != '0) &&
                      ({1'b0, top.size} == total) &&
                      (top.tag == req.elem_type) &&
                      (top.length == req.elem_count) &&
                      (fp >= top.size) &&
                      (exp_addr == {2'b00, req.block_addr});

    // Outcome per request kind.
    always_comb
    begin
        resp.ok         = 1'b0;
        resp.alloc_addr = '0;
        ctl.push        = 1'b0;
        ctl.pop         = 1'b0;
        ctl.fp_next     = fp;
        ctl.frame.size   = total[REGION_W-1:0];
        ctl.frame.tag    = req.elem_type;
        ctl.frame.length = req.elem_count;
        unique case (req.req_type)
            REQ_ALLOC:
            begin
                if (slot_free && fits)
                begin
                    resp.ok         = 1'b1;
                    resp.alloc_addr = base_hdr[FIELD_W-1:0] & ADDR_MASK;
                    ctl.push        = 1'b1;
                    ctl.fp_next     = end_sum[REGION_W-1:0];
                end
            end
            REQ_FREE:
            begin
                if (match)
                begin
                    resp.ok     = 1'b1;
                    ctl.pop     = 1'b1;
                    ctl.fp_next = below[REGION_W-1:0];
                end
            end
            default:
            begin
                resp.ok = 1'b0;
            end
        endcase
    end

endmodule : lts_decide

`default_nettype wire
